/* hdl/tfrg_pkg.sv */
// Package for the table feedback random generator.
// Holds the shared widths, constants and item mode codes. No dependencies.
package tfrg_pkg;

    localparam int WORD_W          = 32;
    localparam int VALUE_W         = 64;
    localparam int MODE_W          = 2;
    localparam int LEN_W           = 6;
    localparam int TABLE_DEPTH_DEF = 256;

    localparam logic [WORD_W-1:0] SEED_MULT = 32'd1812433253;
    localparam logic [LEN_W-1:0]  MAX_BITS  = 6'd32;

    typedef enum logic [MODE_W-1:0] {
        MODE_RESEED = 2'd0,
        MODE_WORD   = 2'd1,
        MODE_DOUBLE = 2'd2,
        MODE_BITS   = 2'd3
    } t_mode;

endpackage

/* hdl/tfrg_ram.sv */
// Generic simple dual port RAM: one write port, two registered read ports.
// Depends on nothing.
module tfrg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

/* hdl/tfrg_bitlen.sv */
// Two-stage significant bit count of a 32-bit word (0 for a zero word).
// Depends on tfrg_pkg.
module tfrg_bitlen (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [tfrg_pkg::WORD_W-1:0] i_word,
    output logic                       o_valid,
    output logic [tfrg_pkg::LEN_W-1:0]  o_len
);
    import tfrg_pkg::*;

    localparam int NBYTES = WORD_W / 8;

    logic       r_valid1;
    logic       r_any;
    logic [1:0] r_idx;
    logic [7:0] r_byte;

    logic       n_any;
    logic [1:0] n_idx;
    logic [7:0] n_byte;
    logic [2:0] bit_pos;

    // stage 1: pick the highest nonzero byte
    always_comb begin
        n_any  = 1'b0;
        n_idx  = '0;
        n_byte = '0;
        for (int b = 0; b < NBYTES; b++) begin
            if (i_word[8*b +: 8] != 8'd0) begin
                n_any  = 1'b1;
                n_idx  = 2'(b);
                n_byte = i_word[8*b +: 8];
            end
        end
    end

    // stage 2: highest set bit inside that byte
    always_comb begin
        bit_pos = '0;
        for (int i = 0; i < 8; i++) begin
            if (r_byte[i]) begin
                bit_pos = 3'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_valid1 <= i_valid;
            o_valid  <= r_valid1;
        end
        r_any  <= n_any;
        r_idx  <= n_idx;
        r_byte <= n_byte;
        o_len  <= r_any ? ({1'b0, r_idx, 3'b000} + {3'b000, bit_pos} + LEN_W'(1)) : '0;
    end

endmodule

/* hdl/table_feedback_random_generator.sv */
// Top level of the table feedback random generator.
// Depends on tfrg_pkg, tfrg_ram and tfrg_bitlen.
//
// Command-style generator over a table of TABLE_DEPTH 32-bit words held in one
// RAM with two registered read ports. An item is taken when start is high and
// busy is low; its single result appears on o_value for exactly one cycle with
// o_done high, and the receiver cannot hold it off. busy drops in the cycle the
// result is shown, so the next item may start there. A draw reads both table
// words, then combines them and writes back (states S_RD, S_WB) when
// TABLE_DEPTH is a power of two; otherwise each draw first reduces the last
// word modulo the depth in S_MOD (a reciprocal multiply, a multiply-subtract,
// one correcting subtract). Mode 1 takes one draw, mode 2 two draws, mode 3
// one draw, then the wait for the bit-length unit and maybe a second draw; an
// invalid bit count in mode 3 returns 0 in the next cycle and draws nothing. A
// reseed computes the table words one multiply step each, in states S_SEED_A
// and S_SEED_B. The table is not cleared at reset: reseed it before the first
// draw, or draws return undefined data.
module table_feedback_random_generator #(
    parameter int TABLE_DEPTH = tfrg_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [tfrg_pkg::MODE_W-1:0]   i_mode,
    input  logic [tfrg_pkg::WORD_W-1:0]   i_operand,
    output logic                          busy,
    output logic                          o_done,
    output logic [tfrg_pkg::VALUE_W-1:0]  o_value
);
    import tfrg_pkg::*;

    localparam int AW      = $clog2(TABLE_DEPTH);
    localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
    localparam logic [AW:0]   DEPTH_W  = (AW+1)'(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
    // floor(2^32 / depth): the quotient estimate is low by at most one
    localparam logic [WORD_W-1:0] RECIP = WORD_W'(64'h1_0000_0000 / TABLE_DEPTH);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SEED_A = 7'b0000010,
        S_SEED_B = 7'b0000100,
        S_MOD    = 7'b0001000,
        S_RD     = 7'b0010000,
        S_WB     = 7'b0100000,
        S_LEN    = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // architectural state
    logic [WORD_W-1:0] r_last;
    logic [AW-1:0]     r_pos;

    // per-item context
    t_mode             r_mode;
    logic [LEN_W-1:0]  r_n;
    logic              r_second;
    logic [WORD_W-1:0] r_hi;
    logic [WORD_W-1:0] r_sh;
    logic [WORD_W-1:0] r_mask;
    logic [AW-1:0]     r_k;
    logic [WORD_W-1:0] r_tmp;
    logic [AW-1:0]     r_rem;
    logic [1:0]        r_mcnt;
    logic [AW:0]       r_quot;
    logic [AW:0]       r_red;

    // RAM ports
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr_b;
    logic [WORD_W-1:0] rd_pos, rd_idx;

    // datapath
    logic [WORD_W-1:0]   prod;
    logic [WORD_W-1:0]   draw_w;
    logic [2*WORD_W-1:0] recip_prod;
    logic [AW:0]         red_nx;
    logic [AW-1:0]       mod_nx;
    logic                mode_bits_ok;
    logic                len_valid;
    logic [LEN_W-1:0]    len;
    logic [LEN_W-1:0]    shift_dn;
    logic [LEN_W-1:0]    shift_up;
    logic                next_is_mod;

    assign busy = (r_state != S_IDLE) || !i_rst_n;

    assign mode_bits_ok = (i_operand != '0) && (i_operand <= WORD_W'(MAX_BITS));
    assign prod         = SEED_MULT * r_tmp;
    assign draw_w       = rd_pos ^ (rd_idx + r_last);
    assign recip_prod   = (2*WORD_W)'(r_last) * (2*WORD_W)'(RECIP);
    assign red_nx       = r_last[AW:0] - r_quot * DEPTH_W;
    assign mod_nx       = (r_red >= DEPTH_W) ? AW'(r_red - DEPTH_W) : AW'(r_red);
    assign shift_dn     = len - r_n;
    assign shift_up     = r_n - len;
    assign next_is_mod  = !IS_POW2;

    assign ram_raddr_b  = IS_POW2 ? r_last[AW-1:0] : r_rem;

    // write during a seed step or on a draw write-back
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = draw_w;
        case (r_state)
            S_SEED_B: begin
                ram_we    = 1'b1;
                ram_waddr = r_k;
                ram_wdata = prod;
            end
            S_WB: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    tfrg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (r_pos),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (rd_pos),
        .o_rdata_b (rd_idx)
    );

    tfrg_bitlen u_bitlen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid ((r_state == S_WB) && (r_mode == MODE_BITS) && !r_second),
        .i_word  (draw_w),
        .o_valid (len_valid),
        .o_len   (len)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (t_mode'(i_mode))
                        MODE_RESEED: n_state = S_SEED_A;
                        MODE_BITS:   n_state = mode_bits_ok ?
                                               (next_is_mod ? S_MOD : S_RD) : S_IDLE;
                        default:     n_state = next_is_mod ? S_MOD : S_RD;
                    endcase
                end
            end
            S_SEED_A: n_state = S_SEED_B;
            S_SEED_B: n_state = (r_k == LAST_IDX) ? S_IDLE : S_SEED_A;
            S_MOD:    n_state = (r_mcnt == 2'd2) ? S_RD : S_MOD;
            S_RD:     n_state = S_WB;
            S_WB: begin
                case (r_mode)
                    MODE_DOUBLE: n_state = r_second ? S_IDLE
                                                    : (next_is_mod ? S_MOD : S_RD);
                    MODE_BITS:   n_state = r_second ? S_IDLE : S_LEN;
                    default:     n_state = S_IDLE;
                endcase
            end
            S_LEN: begin
                if (len_valid) begin
                    n_state = (len >= r_n) ? S_IDLE : (next_is_mod ? S_MOD : S_RD);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= '0;
            r_pos   <= '0;
            o_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            o_done  <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_mode   <= t_mode'(i_mode);
                        r_n      <= i_operand[LEN_W-1:0];
                        r_second <= 1'b0;
                        r_k      <= '0;
                        r_rem    <= '0;
                        r_mcnt   <= '0;
                        if (t_mode'(i_mode) == MODE_RESEED) begin
                            r_last <= i_operand;
                        end
                        // invalid bit count: answer zero at once, draw nothing
                        if (t_mode'(i_mode) == MODE_BITS && !mode_bits_ok) begin
                            o_done  <= 1'b1;
                            o_value <= '0;
                        end
                    end
                end
                S_SEED_A: begin
                    r_tmp <= (r_last ^ (r_last >> 30)) + WORD_W'(r_k) + WORD_W'(1);
                end
                S_SEED_B: begin
                    r_last <= prod;
                    r_k    <= r_k + 1'b1;
                    if (r_k == LAST_IDX) begin
                        r_pos   <= '0;
                        o_done  <= 1'b1;
                        o_value <= '0;
                    end
                end
                S_MOD: begin
                    // estimate the quotient, take the remainder, fold it below the depth
                    case (r_mcnt)
                        2'd0:    r_quot <= recip_prod[WORD_W +: AW+1];
                        2'd1:    r_red  <= red_nx;
                        default: r_rem  <= mod_nx;
                    endcase
                    r_mcnt <= r_mcnt + 1'b1;
                end
                S_WB: begin
                    r_last <= draw_w;
                    r_pos  <= (r_pos == LAST_IDX) ? '0 : r_pos + 1'b1;
                    r_rem  <= '0;
                    r_mcnt <= '0;
                    case (r_mode)
                        MODE_DOUBLE: begin
                            if (r_second) begin
                                o_done  <= 1'b1;
                                o_value <= {r_hi, draw_w};
                            end else begin
                                r_hi     <= draw_w;
                                r_second <= 1'b1;
                            end
                        end
                        MODE_BITS: begin
                            if (r_second) begin
                                o_done  <= 1'b1;
                                o_value <= {{WORD_W{1'b0}}, r_sh | (draw_w & r_mask)};
                            end else begin
                                r_hi <= draw_w;
                            end
                        end
                        default: begin
                            o_done  <= 1'b1;
                            o_value <= {{WORD_W{1'b0}}, draw_w};
                        end
                    endcase
                end
                S_LEN: begin
                    if (len_valid) begin
                        if (len >= r_n) begin
                            // enough significant bits: keep the top n of them
                            o_done  <= 1'b1;
                            o_value <= {{WORD_W{1'b0}}, r_hi >> shift_dn};
                        end else begin
                            // too short: shift up and fill from a second draw
                            r_sh     <= r_hi << shift_up;
                            r_mask   <= {WORD_W{1'b1}} >> (MAX_BITS - shift_up);
                            r_second <= 1'b1;
                        end
                    end
                end
                default: begin
                    o_done <= 1'b0;
                end
            endcase
        end
    end

endmodule

/* dv/tb.sv */
// Testbench for table_feedback_random_generator.
// Depends on tfrg_pkg and the RTL of the block; needs nothing else to run.
`timescale 1ns / 1ps

module tb;
    import tfrg_pkg::*;

    localparam int DEPTH    = TABLE_DEPTH_DEF;
    localparam int MAX_GAP  = 10;
    localparam int N_RANDOM = 1400;
    localparam int MAX_MISMATCH_PRINTS = 20;

    // One item as the driver presents it. Set hold_until_idle to make the
    // driver wait until every expected result has come before it starts.
    typedef struct {
        t_mode       mode;
        logic [31:0] operand;
        bit          hold_until_idle;
    } t_item;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 start     = 1'b0;
    logic [MODE_W-1:0]    i_mode    = '0;
    logic [WORD_W-1:0]    i_operand = '0;
    logic                 busy;
    logic                 o_done;
    logic [VALUE_W-1:0]   o_value;

    table_feedback_random_generator #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_mode   (i_mode),
        .i_operand(i_operand),
        .busy     (busy),
        .o_done   (o_done),
        .o_value  (o_value)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Generator state as the testbench tracks it: the word table, the
    // last word drawn and the draw position.
    // ------------------------------------------------------------------
    logic [31:0] gen_tbl [DEPTH];
    logic [31:0] gen_last = '0;
    int          gen_pos  = 0;

    // Draw one word: mix the word at the position with the word that the
    // last draw points at, write it back, advance the position.
    function automatic logic [31:0] next_word();
        logic [31:0] w;
        w = gen_tbl[gen_pos] ^ (gen_tbl[gen_last % DEPTH] + gen_last);
        gen_tbl[gen_pos] = w;
        gen_last = w;
        gen_pos = (gen_pos + 1) % DEPTH;
        return w;
    endfunction

    // Refill the whole table from a seed with the multiplicative recurrence.
    function automatic void refill_table(input logic [31:0] seed);
        logic [31:0] v;
        v = seed;
        for (int k = 1; k <= DEPTH; k++) begin
            v = SEED_MULT * ((v ^ (v >> 30)) + 32'(k));
            gen_tbl[k-1] = v;
        end
        gen_last = v;
        gen_pos = 0;
    endfunction

    // Return n random bits: the top n significant bits of one draw, or that
    // draw shifted up and topped off from a second draw when it is too short.
    function automatic logic [63:0] take_bits(input logic [31:0] n);
        logic [31:0] r, d, m;
        int          j, nb;
        if (n == 0 || n > 32)
            return '0;
        nb = int'(n);
        r = next_word();
        j = 0;
        while (j < 32 && (r >> j) != 0)
            j++;
        if (j >= nb)
            return 64'(r >> (j - nb));
        m = (32'hffff_ffff >> (32 - nb)) >> j;
        r = (nb - j < 32) ? (r << (nb - j)) : 32'h0;
        d = next_word();
        return 64'(r | (d & m));
    endfunction

    function automatic logic [63:0] predict_value(input t_mode mode,
                                                  input logic [31:0] operand);
        logic [63:0] hi;
        case (mode)
            MODE_RESEED: begin
                refill_table(operand);
                return '0;
            end
            MODE_WORD:   return 64'(next_word());
            MODE_DOUBLE: begin
                hi = 64'(next_word());
                return (hi << 32) | 64'(next_word());
            end
            default:     return take_bits(operand);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus store and bookkeeping
    // ------------------------------------------------------------------
    t_item       pending_items [$];
    logic [63:0] value_q [$];
    longint      cycle_limit = 64'd2_000_000;
    longint      cycle_cnt   = 0;
    longint      slow_budget = 0;
    int          err_cnt     = 0;
    int          n_reseed = 0, n_word = 0, n_double = 0, n_bits = 0, n_bad_bits = 0;
    bit          took = 1'b0;

    // Queue one item and add its worst-case cycle cost to the run budget.
    task automatic add_item(input t_mode mode, input logic [31:0] operand,
                            input bit hold = 1'b0);
        t_item it;
        it.mode = mode;
        it.operand = operand;
        it.hold_until_idle = hold;
        pending_items.push_back(it);
        slow_budget += (mode == MODE_RESEED) ? (2 * DEPTH + 8) : 16;
        slow_budget += MAX_GAP + 2;
    endtask

    // ------------------------------------------------------------------
    // Driver: changes inputs at the falling edge. Hold the item while it
    // is not taken; once taken, advance to the next item or idle for a gap.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge i_clk) begin : driver
        t_item it;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !took) begin
            // hold: the block is still busy with the previous item
        end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
        end else if (pending_items.size() == 0) begin
            start <= 1'b0;
        end else if (pending_items[0].hold_until_idle && value_q.size() != 0) begin
            // drain: wait for every outstanding result before starting
            start <= 1'b0;
        end else begin
            it = pending_items.pop_front();
            i_mode    <= it.mode;
            i_operand <= it.operand;
            start     <= 1'b1;
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                // pick the next burst; now and then a long one with no idling
                burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(0, 15);
                gap_left   = $urandom_range(1, MAX_GAP);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: samples at the rising edge. Check any result against the
    // oldest expectation first, then predict for an item taken at this edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        logic [63:0] want;
        t_mode       m;
        if (!i_rst_n) begin
            took <= 1'b0;
        end else begin
            if (o_done === 1'b1) begin
                if (value_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_MISMATCH_PRINTS)
                        $display("%0t: result with nothing expected, value %h",
                                 $time, o_value);
                end else begin
                    want = value_q.pop_front();
                    if (o_value !== want) begin
                        err_cnt++;
                        if (err_cnt <= MAX_MISMATCH_PRINTS)
                            $display("%0t: value mismatch, expected %h, actual %h",
                                     $time, want, o_value);
                    end
                end
            end
            took <= start && (busy === 1'b0);
            if (start && busy === 1'b0) begin
                m = t_mode'(i_mode);
                value_q.push_back(predict_value(m, i_operand));
                case (m)
                    MODE_RESEED: n_reseed++;
                    MODE_WORD:   n_word++;
                    MODE_DOUBLE: n_double++;
                    default: begin
                        n_bits++;
                        if (i_operand == 0 || i_operand > 32)
                            n_bad_bits++;
                    end
                endcase
            end
        end
    end

    // Watchdog on a cycle count well beyond the slowest correct run.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > cycle_limit) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        int          pick;
        logic [31:0] seed;
        logic [31:0] n;

        // Directed part. The table is reseeded before any draw, always.
        add_item(MODE_RESEED, 32'h0000_0000);
        add_item(MODE_WORD,   32'h0000_0000);
        add_item(MODE_WORD,   32'hffff_ffff);
        add_item(MODE_DOUBLE, 32'h0000_0000);
        add_item(MODE_DOUBLE, 32'hffff_ffff);
        add_item(MODE_BITS,   32'd1);
        add_item(MODE_BITS,   32'd32);
        add_item(MODE_BITS,   32'd31);
        add_item(MODE_BITS,   32'd2);
        add_item(MODE_BITS,   32'd16);
        // invalid bit counts: zero, just past the top, the widest operand, low bits 32
        add_item(MODE_BITS,   32'd0, 1'b1);
        add_item(MODE_BITS,   32'd33);
        add_item(MODE_BITS,   32'hffff_ffff);
        add_item(MODE_BITS,   32'h8000_0020);
        add_item(MODE_RESEED, 32'hffff_ffff);
        add_item(MODE_BITS,   32'd32);
        add_item(MODE_WORD,   32'h5555_5555);
        add_item(MODE_RESEED, 32'h8000_0000);
        add_item(MODE_DOUBLE, 32'haaaa_aaaa);
        add_item(MODE_BITS,   32'd8);
        add_item(MODE_RESEED, 32'h7fff_ffff);
        add_item(MODE_WORD,   32'h0000_0001);

        // Random part: mostly draws on a seeded table, with a reseed now and
        // then and a slice of bad bit counts.
        for (int i = 0; i < N_RANDOM; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                case ($urandom_range(0, 5))
                    0:       seed = 32'h0000_0000;
                    1:       seed = 32'hffff_ffff;
                    default: seed = $urandom;
                endcase
                add_item(MODE_RESEED, seed, i == N_RANDOM / 2);
            end else if (pick < 33) begin
                add_item(MODE_WORD, $urandom, i == N_RANDOM / 2);
            end else if (pick < 58) begin
                add_item(MODE_DOUBLE, $urandom, i == N_RANDOM / 2);
            end else begin
                case ($urandom_range(0, 19))
                    0:       n = 32'd0;
                    1:       n = $urandom_range(33, 63);
                    2:       n = $urandom | 32'h0000_0040;
                    3:       n = 32'd32;
                    default: n = $urandom_range(1, 32);
                endcase
                add_item(MODE_BITS, n, (i == N_RANDOM / 2) || ($urandom_range(0, 199) == 0));
            end
        end

        cycle_limit = 4 * slow_budget + 2000;

        // Hold reset, then release it on a falling edge.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every item taken, every result back, then a short tail.
        while (pending_items.size() != 0 || start || value_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d reseeds, %0d word draws, %0d double draws,",
                 n_reseed, n_word, n_double);
        $display("and %0d bit draws (%0d with a bad count), %0d mismatches.",
                 n_bits, n_bad_bits, err_cnt);
        if (err_cnt == 0 && value_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
